FILE: src/integer_matrix_multiply_top_macros.svh
// assertion macros for the integer matrix multiply checker
// no dependencies; included by the checker file only
`ifndef INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_TOP_MACROS_SVH

// same-cycle implication
`define IMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/imm_pkg.sv
// shared types and constants for the integer matrix multiply block
// no dependencies
package imm_pkg;

  localparam int MAX_DIM   = 8;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DIM_W     = 4;
  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 2;
  localparam int REG_IDX_W = 2;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MULTIPLY = 2'd2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product;
    logic                     last;
  } out_item_t;

  // control that travels with the operands into the mac
  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

endpackage

FILE: src/imm_store.sv
// element storage for matrices a and b, one write port, registered reads
// depends on imm_pkg
module imm_store import imm_pkg::*; (
  input  logic              clk,
  input  logic              we_a,
  input  logic              we_b,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_a,
  output logic [DATA_W-1:0] rd_b
);

  logic [DATA_W-1:0] mem_a [MEM_DEPTH];
  logic [DATA_W-1:0] mem_b [MEM_DEPTH];

  // matrix a
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[rd_addr_a];
  end

  // matrix b
  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b <= mem_b[rd_addr_b];
  end

endmodule

FILE: src/imm_mac.sv
// shared multiply-accumulate unit, registered product then 32-bit wrap sum
// depends on imm_pkg
module imm_mac import imm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mac_ctl_t          mac_ctl,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] acc
);

  logic [DATA_W-1:0] prod;
  logic              prod_valid;
  logic              prod_first;

  // product stage, low word only
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= mac_ctl.valid;
    end
    prod_first <= mac_ctl.first;
    prod       <= a * b;
  end

  // accumulate stage, restarts on the first term of a dot product
  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= (prod_first ? '0 : acc) + prod;
    end
  end

endmodule

FILE: src/imm_ctrl.sv
// sequencer: config registers, input decode, loop counters, output register
// depends on imm_pkg
module imm_ctrl import imm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  output logic                 we_a,
  output logic                 we_b,
  output logic [ADDR_W-1:0]    wr_addr,
  output logic [DATA_W-1:0]    wr_data,
  output logic [ADDR_W-1:0]    rd_addr_a,
  output logic [ADDR_W-1:0]    rd_addr_b,
  output mac_ctl_t             mac_ctl,
  input  logic [DATA_W-1:0]    acc
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  // read register, product register, accumulator
  localparam logic [1:0] DRAIN_LAST = 2'd2;

  state_t           state;
  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] inner_dim;
  logic [DIM_W-1:0] cols_b;
  logic [DIM_W-1:0] nr;
  logic [DIM_W-1:0] nk;
  logic [DIM_W-1:0] nc;
  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] c;
  logic [IDX_W-1:0] k;
  logic [1:0]       drain_cnt;

  logic             in_xfer;
  logic             r_last;
  logic             c_last;
  logic             k_last;
  logic             nk_zero;
  logic [DIM_W-1:0] start_nr;
  logic [DIM_W-1:0] start_nk;
  logic [DIM_W-1:0] start_nc;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    clamp_dim = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // element writes go straight to the stores
  assign we_a    = in_xfer && (in_data.func == FUNC_WRITE_A);
  assign we_b    = in_xfer && (in_data.func == FUNC_WRITE_B);
  assign wr_addr = {in_data.row, in_data.col};
  assign wr_data = in_data.value;

  // operand addresses for a[r][k] and b[k][c]
  assign rd_addr_a = {r, k};
  assign rd_addr_b = {k, c};

  assign r_last  = ({1'b0, r} == nr - DIM_W'(1));
  assign c_last  = ({1'b0, c} == nc - DIM_W'(1));
  assign k_last  = ({1'b0, k} == nk - DIM_W'(1));
  assign nk_zero = (nk == '0);

  assign start_nr = clamp_dim(rows_a);
  assign start_nk = clamp_dim(inner_dim);
  assign start_nc = clamp_dim(cols_b);

  // state, counters, config and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      mac_ctl.valid <= 1'b0;
      rows_a        <= DIM_W'(MAX_DIM);
      inner_dim     <= DIM_W'(MAX_DIM);
      cols_b        <= DIM_W'(MAX_DIM);
    end else begin
      mac_ctl.valid <= (state == S_RUN);
      mac_ctl.first <= (k == '0);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_A:    rows_a    <= cfg_data;
          REG_INNER_DIM: inner_dim <= cfg_data;
          REG_COLS_B:    cols_b    <= cfg_data;
          default:       ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_xfer && (in_data.func == FUNC_MULTIPLY) &&
              (start_nr != '0) && (start_nc != '0)) begin
            nr <= start_nr;
            nk <= start_nk;
            nc <= start_nc;
            r  <= '0;
            c  <= '0;
            k  <= '0;
            if (start_nk == '0) begin
              state     <= S_DRAIN;
              drain_cnt <= DRAIN_LAST;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (k_last) begin
            state     <= S_DRAIN;
            drain_cnt <= '0;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (drain_cnt == DRAIN_LAST) begin
            out_data.out_row <= r;
            out_data.out_col <= c;
            out_data.product <= nk_zero ? '0 : acc;
            out_data.last    <= r_last && c_last;
            out_valid        <= 1'b1;
            state            <= S_EMIT;
          end else begin
            drain_cnt <= drain_cnt + 2'd1;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last) begin
              state <= S_IDLE;
            end else begin
              k <= '0;
              if (c_last) begin
                c <= '0;
                r <= r + IDX_W'(1);
              end else begin
                c <= c + IDX_W'(1);
              end
              if (nk_zero) begin
                state     <= S_DRAIN;
                drain_cnt <= DRAIN_LAST;
              end else begin
                state <= S_RUN;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/integer_matrix_multiply_top.sv
// integer matrix multiply: element writes go straight to the stores while idle.
// a multiply is set by one shared multiply-accumulate: for each product element,
// inner_dim operand reads, a drain through the mac registers, and one output
// transfer that waits on out_ready. ready is low until the last one.
// synchronous active-high reset returns dimensions to 8 and idles the sequencer;
// the element stores are not cleared.
module integer_matrix_multiply_top import imm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  logic              we_a;
  logic              we_b;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  mac_ctl_t          mac_ctl;
  logic [DATA_W-1:0] acc;

  // sequencer
  imm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .we_a      (we_a),
    .we_b      (we_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .mac_ctl   (mac_ctl),
    .acc       (acc)
  );

  // matrix storage
  imm_store u_store (
    .clk       (clk),
    .we_a      (we_a),
    .we_b      (we_b),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // shared multiply-accumulate
  imm_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .mac_ctl (mac_ctl),
    .a       (rd_a),
    .b       (rd_b),
    .acc     (acc)
  );

endmodule

FILE: src/imm_checker.sv
// port-level checks for the integer matrix multiply top, attached by bind
// depends on imm_pkg and integer_matrix_multiply_top_macros.svh
`include "integer_matrix_multiply_top_macros.svh"

module imm_checker import imm_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result stays offered
  `IMM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped before transfer")

  // no input taken while a result is pending
  `IMM_ASSERT_SAME(a_busy_emit, clk, rst, out_valid, !in_ready, "input ready while result pending")

  // the final element frees the block
  `IMM_ASSERT_NEXT(a_last_idle, clk, rst, out_valid && out_ready && out_data.last, in_ready && !out_valid, "block not idle after last element")

  // writes and unused codes leave the block ready
  `IMM_ASSERT_NEXT(a_write_ready, clk, rst, in_valid && in_ready && (in_data.func != FUNC_MULTIPLY), in_ready, "block busy after element write")

endmodule

bind integer_matrix_multiply_top imm_checker u_imm_checker (.*);

FILE: test/integer_matrix_multiply_top_test.sv
// self-checking testbench for integer_matrix_multiply_top: loads both matrices,
// requests products under a range of dimension settings and checks every element
// against a behavioral predictor; depends on imm_pkg and the top-level rtl only
module integer_matrix_multiply_top_test;
  import imm_pkg::*;

  localparam int IDLE_PCT     = 23;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 31;
  localparam int STEADY_PHASE = 4;

  // code that the block ignores, and a register index past the last register
  localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_NONE    = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;

  // pending stimulus and expected product elements
  in_item_t  item_q[$];
  out_item_t product_q[$];

  // predictor state
  logic [DATA_W-1:0] mat_a [MEM_DEPTH];
  logic [DATA_W-1:0] mat_b [MEM_DEPTH];
  logic [DIM_W-1:0]  dim_rows, dim_inner, dim_cols;

  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;
  logic steady = 1'b0;
  int   n_queued = 0;
  int   n_accepted = 0;
  int   error_count = 0;
  int   stall_cycles = 0;

  // dimension plan per phase; the last phase picks its own
  int plan_rows  [N_PHASES] = '{1, 0, 3, 2, 15,  9, 3, 8, 1, 0};
  int plan_inner [N_PHASES] = '{1, 3, 3, 0, 15, 12, 5, 1, 8, 0};
  int plan_cols  [N_PHASES] = '{1, 3, 0, 3, 15, 10, 2, 8, 1, 0};

  integer_matrix_multiply_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // element writes update the matrices, a multiply produces every element of C
  task automatic apply_item(input in_item_t it);
    int nr, nk, nc;
    logic [DATA_W-1:0] acc;
    out_item_t elem;
    case (it.func)
      FUNC_WRITE_A: mat_a[{it.row, it.col}] = it.value;
      FUNC_WRITE_B: mat_b[{it.row, it.col}] = it.value;
      FUNC_MULTIPLY: begin
        nr = (dim_rows > MAX_DIM) ? MAX_DIM : dim_rows;
        nk = (dim_inner > MAX_DIM) ? MAX_DIM : dim_inner;
        nc = (dim_cols > MAX_DIM) ? MAX_DIM : dim_cols;
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            acc = '0;
            for (int k = 0; k < nk; k++)
              acc = acc + mat_a[{IDX_W'(r), IDX_W'(k)}] * mat_b[{IDX_W'(k), IDX_W'(c)}];
            elem.out_row = IDX_W'(r);
            elem.out_col = IDX_W'(c);
            elem.product = acc;
            elem.last    = (r + 1 == nr) && (c + 1 == nc);
            product_q.push_back(elem);
          end
        end
      end
      default: ;
    endcase
  endtask

  // compare one output transfer with the oldest expected element
  task automatic check_product(input out_item_t got);
    out_item_t want;
    if (product_q.size() == 0) begin
      $display("%0t: unexpected product element row %0d col %0d value %0d last %0b",
               $time, got.out_row, got.out_col, got.product, got.last);
      error_count++;
    end else begin
      want = product_q.pop_front();
      if (got.out_row !== want.out_row) begin
        $display("%0t: out_row expected %0d, got %0d", $time, want.out_row, got.out_row);
        error_count++;
      end
      if (got.out_col !== want.out_col) begin
        $display("%0t: out_col expected %0d, got %0d", $time, want.out_col, got.out_col);
        error_count++;
      end
      if (got.product !== want.product) begin
        $display("%0t: product at (%0d,%0d) expected %0d, got %0d", $time,
                 want.out_row, want.out_col, want.product, got.product);
        error_count++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last at (%0d,%0d) expected %0b, got %0b", $time,
                 want.out_row, want.out_col, want.last, got.last);
        error_count++;
      end
    end
  endtask

  // monitor: sample every transfer at the rising edge
  always @(posedge clk) begin
    in_taken  <= !rst && in_valid && in_ready;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (rst) begin
      dim_rows  = 4'd8;
      dim_inner = 4'd8;
      dim_cols  = 4'd8;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROWS_A:    dim_rows  = cfg_data;
          REG_INNER_DIM: dim_inner = cfg_data;
          REG_COLS_B:    dim_cols  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        apply_item(in_data);
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready)
        check_product(out_data);
    end
  end

  // driver: next item goes out once the current one is transferred
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (item_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= item_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
    in_item_t it;
    it.func  = f;
    it.row   = r;
    it.col   = c;
    it.value = v;
    item_q.push_back(it);
    n_queued++;
  endtask

  // one register write over the configuration channel
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // wait until every item is in and every product element is out, then drain
  task automatic settle();
    do @(negedge clk); while (n_accepted != n_queued || product_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int roll;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full-size dimensions, then load every element of both matrices
    write_reg(REG_ROWS_A, 4'd8);
    write_reg(REG_INNER_DIM, 4'd8);
    write_reg(REG_COLS_B, 4'd8);
    @(posedge clk);
    for (int i = 0; i < MEM_DEPTH; i++) begin
      queue_item(FUNC_WRITE_A, IDX_W'(i / MAX_DIM), IDX_W'(i % MAX_DIM), $urandom());
      queue_item(FUNC_WRITE_B, IDX_W'(i / MAX_DIM), IDX_W'(i % MAX_DIM), $urandom());
    end

    // extreme values, the ignored code, and a multiply carrying a nonzero value
    queue_item(FUNC_WRITE_A, 3'd0, 3'd0, 32'h8000_0000);
    queue_item(FUNC_WRITE_B, 3'd0, 3'd0, 32'h8000_0000);
    queue_item(FUNC_WRITE_A, 3'd7, 3'd7, 32'h7fff_ffff);
    queue_item(FUNC_WRITE_B, 3'd7, 3'd7, 32'h7fff_ffff);
    queue_item(FUNC_WRITE_A, 3'd3, 3'd5, 32'hffff_ffff);
    queue_item(FUNC_WRITE_B, 3'd5, 3'd3, 32'hffff_ffff);
    queue_item(FUNC_WRITE_A, 3'd6, 3'd1, 32'h0000_0000);
    queue_item(FUNC_UNUSED, 3'd7, 3'd7, 32'h5a5a_5a5a);
    queue_item(FUNC_MULTIPLY, 3'd7, 3'd7, 32'hffff_ffff);

    // random phases under different dimensions, extremes and saturation included
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      steady <= 1'b0;
      if (p == N_PHASES - 1) begin
        plan_rows[p]  = $urandom_range(1, 4);
        plan_inner[p] = $urandom_range(1, 4);
        plan_cols[p]  = $urandom_range(1, 4);
      end
      write_reg(REG_ROWS_A, DIM_W'(plan_rows[p]));
      write_reg(REG_INNER_DIM, DIM_W'(plan_inner[p]));
      write_reg(REG_COLS_B, DIM_W'(plan_cols[p]));
      if (p == 6)
        write_reg(REG_NONE, DIM_W'($urandom_range(15)));
      @(posedge clk);
      if (p == STEADY_PHASE)
        steady <= 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(99);
        if (roll < 8)
          queue_item(FUNC_MULTIPLY, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                     $urandom());
        else if (roll < 14)
          queue_item(FUNC_UNUSED, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                     $urandom());
        else
          queue_item($urandom_range(1) ? FUNC_WRITE_B : FUNC_WRITE_A,
                     IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)), $urandom());
      end
      queue_item(FUNC_MULTIPLY, IDX_W'($urandom_range(7)), IDX_W'($urandom_range(7)),
                 $urandom());
    end

    settle();
    error_count += product_q.size();
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/imm_pkg.sv
src/imm_store.sv
src/imm_mac.sv
src/imm_ctrl.sv
src/integer_matrix_multiply_top.sv
src/imm_checker.sv
test/integer_matrix_multiply_top_test.sv
